// ===== design/stl_pkg.sv =====
// Shared types and constants for the sorted tick list engine.
package stl_pkg;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 4;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int HEAD_W  = 5;
  localparam int ERR_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR         = 2'd0,
    CMD_INSERT_SORTED = 2'd1,
    CMD_INSERT_END    = 2'd2,
    CMD_REMOVE        = 2'd3
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK     = 2'd0,
    ERR_LISTED = 2'd1,
    ERR_ABSENT = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_LINK1,
    ST_LINK2,
    ST_UNLINK,
    ST_HEAD,
    ST_HVAL
  } state_e;

  // Address driven onto the shared link/value memory read port
  typedef enum logic [1:0] {
    RD_ID,
    RD_HEAD,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    in_ready;
    logic    clear;
    logic    set_err;
    err_e    err;
    logic    wr_value;
    rd_sel_e rd_sel;
    logic    start_end;
    logic    start_sorted;
    logic    walk_adv;
    logic    link1;
    logic    link2;
    logic    unlink;
    logic    out_load;
  } stl_ctrl_t;

  typedef struct packed {
    logic in_valid;
    cmd_e cmd;
    logic id_ok;
    logic listed;
    logic val_max;
    logic head_empty;
    logic walk_stop;
    logic next_sent;
    logic out_free;
  } stl_stat_t;

endpackage

// ===== design/stl_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one command word.
interface stl_cmd_if import stl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [ID_W-1:0]    item_id;
  logic [VALUE_W-1:0] item_value;

  modport source (output valid, output command, output item_id, output item_value,
                  input ready);
  modport sink   (input valid, input command, input item_id, input item_value,
                  output ready);
endinterface

// ===== design/stl_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one status word.
interface stl_rsp_if import stl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] item_count;
  logic [HEAD_W-1:0]  head_item;
  logic [VALUE_W-1:0] head_value;
  logic [ERR_W-1:0]   error_code;

  modport source (output valid, output item_count, output head_item, output head_value,
                  output error_code, input ready);
  modport sink   (input valid, input item_count, input head_item, input head_value,
                  input error_code, output ready);
endinterface

// ===== design/stl_ctrl.sv =====
// Command sequencer for the sorted tick list engine.
module stl_ctrl import stl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stl_stat_t stat_i,
  output stl_ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '{err: ERR_OK, rd_sel: RD_HEAD, default: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        ctrl_o.set_err = 1'b1;
        unique case (stat_i.cmd)
          CMD_CLEAR: begin
            ctrl_o.clear = 1'b1;
            state_d      = ST_HEAD;
          end
          CMD_REMOVE: begin
            // links of the slot come back next cycle
            ctrl_o.rd_sel = RD_ID;
            if (!stat_i.listed) begin
              ctrl_o.err = ERR_ABSENT;
              state_d    = ST_HEAD;
            end else begin
              state_d = ST_UNLINK;
            end
          end
          CMD_INSERT_SORTED, CMD_INSERT_END: begin
            if (!stat_i.id_ok) begin
              ctrl_o.err = ERR_ABSENT;
              state_d    = ST_HEAD;
            end else if (stat_i.listed) begin
              ctrl_o.err = ERR_LISTED;
              state_d    = ST_HEAD;
            end else begin
              ctrl_o.wr_value = 1'b1;
              if (stat_i.cmd == CMD_INSERT_END || stat_i.val_max) begin
                ctrl_o.start_end = 1'b1;
                state_d          = ST_LINK1;
              end else begin
                ctrl_o.start_sorted = 1'b1;
                ctrl_o.rd_sel       = RD_HEAD;
                state_d             = stat_i.head_empty ? ST_LINK1 : ST_WALK;
              end
            end
          end
          default: state_d = ST_HEAD;
        endcase
      end

      ST_WALK: begin
        // one list node per cycle; stop at first larger value or the sentinel
        if (stat_i.walk_stop) begin
          state_d = ST_LINK1;
        end else begin
          ctrl_o.walk_adv = 1'b1;
          ctrl_o.rd_sel   = RD_NEXT;
          if (stat_i.next_sent) begin
            state_d = ST_LINK1;
          end
        end
      end

      ST_LINK1: begin
        ctrl_o.link1 = 1'b1;
        state_d      = ST_LINK2;
      end

      ST_LINK2: begin
        ctrl_o.link2 = 1'b1;
        state_d      = ST_HEAD;
      end

      ST_UNLINK: begin
        ctrl_o.unlink = 1'b1;
        state_d       = ST_HEAD;
      end

      ST_HEAD: begin
        ctrl_o.rd_sel = RD_HEAD;
        state_d       = ST_HVAL;
      end

      ST_HVAL: begin
        ctrl_o.rd_sel = RD_HEAD;
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== design/stl_dp.sv =====
// List storage, link memories, walk registers and response register.
module stl_dp import stl_pkg::*; #(
  parameter int MAX_ITEMS  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stl_cmd_if.sink    cmd_i,
  stl_rsp_if.source  rsp_o,
  input  stl_ctrl_t  ctrl_i,
  output stl_stat_t  stat_o
);

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int LW = $clog2(MAX_ITEMS + 1);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [LW-1:0] SENT = LW'(MAX_ITEMS);

  // command word
  cmd_e                  cmd_q;
  logic [ID_W-1:0]       id_q;
  logic [VALUE_BITS-1:0] val_q;

  // list state; sentinel links live in head/tail registers
  logic [LW-1:0]        head_q, head_d;
  logic [LW-1:0]        tail_q, tail_d;
  logic [CW-1:0]        count_q, count_d;
  logic [MAX_ITEMS-1:0] in_list_q, in_list_d;

  // walk registers: insert goes between pos and cur
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] cur_q, cur_d;
  err_e          err_q;

  logic [LW-1:0] next_mem  [MAX_ITEMS];
  logic [LW-1:0] prev_mem  [MAX_ITEMS];
  logic [VALUE_BITS-1:0] value_mem [MAX_ITEMS];

  logic [LW-1:0]         next_rd_q, prev_rd_q;
  logic [VALUE_BITS-1:0] value_rd_q;

  logic [LW-1:0]         rd_addr;
  logic                  next_we, prev_we;
  logic [LW-1:0]         next_wa, next_wd, prev_wa, prev_wd;
  logic [LW-1:0]         id_link;
  logic [IW-1:0]         id_idx;
  logic                  id_ok;
  logic                  in_fire;

  // response register
  logic               out_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [HEAD_W-1:0]  out_head_q;
  logic [VALUE_W-1:0] out_value_q;
  err_e               out_err_q;

  assign in_fire = cmd_i.valid && ctrl_i.in_ready;
  assign cmd_i.ready = ctrl_i.in_ready;

  assign id_ok   = 32'(id_q) < 32'(MAX_ITEMS);
  assign id_link = LW'(id_q);
  assign id_idx  = IW'(id_q);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_e'(cmd_i.command);
      id_q  <= cmd_i.item_id;
      val_q <= VALUE_BITS'(cmd_i.item_value);
    end
  end

  assign stat_o.in_valid   = cmd_i.valid;
  assign stat_o.cmd        = cmd_q;
  assign stat_o.id_ok      = id_ok;
  assign stat_o.listed     = id_ok && in_list_q[id_idx];
  assign stat_o.val_max    = &val_q;
  assign stat_o.head_empty = (head_q == SENT);
  assign stat_o.walk_stop  = (value_rd_q > val_q);
  assign stat_o.next_sent  = (next_rd_q == SENT);
  assign stat_o.out_free   = !out_valid_q || rsp_o.ready;

  always_comb begin
    unique case (ctrl_i.rd_sel)
      RD_ID:   rd_addr = id_link;
      RD_NEXT: rd_addr = next_rd_q;
      default: rd_addr = head_q;
    endcase
  end

  // memory write ports
  always_comb begin
    next_we = 1'b0;
    next_wa = id_link;
    next_wd = cur_q;
    prev_we = 1'b0;
    prev_wa = id_link;
    prev_wd = pos_q;
    if (ctrl_i.link1) begin
      next_we = 1'b1;
      prev_we = 1'b1;
    end else if (ctrl_i.link2) begin
      next_we = (pos_q != SENT);
      next_wa = pos_q;
      next_wd = id_link;
      prev_we = (cur_q != SENT);
      prev_wa = cur_q;
      prev_wd = id_link;
    end else if (ctrl_i.unlink) begin
      next_we = (prev_rd_q != SENT);
      next_wa = prev_rd_q;
      next_wd = next_rd_q;
      prev_we = (next_rd_q != SENT);
      prev_wa = next_rd_q;
      prev_wd = prev_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa[IW-1:0]] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa[IW-1:0]] <= prev_wd;
    end
    if (ctrl_i.wr_value) begin
      value_mem[id_idx] <= val_q;
    end
    next_rd_q  <= next_mem[rd_addr[IW-1:0]];
    prev_rd_q  <= prev_mem[rd_addr[IW-1:0]];
    value_rd_q <= value_mem[rd_addr[IW-1:0]];
  end

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    in_list_d = in_list_q;
    pos_d     = pos_q;
    cur_d     = cur_q;
    if (ctrl_i.clear) begin
      head_d    = SENT;
      tail_d    = SENT;
      count_d   = '0;
      in_list_d = '0;
    end
    if (ctrl_i.start_end) begin
      pos_d = tail_q;
      cur_d = SENT;
    end
    if (ctrl_i.start_sorted) begin
      pos_d = SENT;
      cur_d = head_q;
    end
    if (ctrl_i.walk_adv) begin
      pos_d = cur_q;
      cur_d = next_rd_q;
    end
    if (ctrl_i.link2) begin
      // count moves together with head/tail
      if (pos_q == SENT) head_d = id_link;
      if (cur_q == SENT) tail_d = id_link;
      in_list_d[id_idx] = 1'b1;
      count_d           = count_q + CW'(1);
    end
    if (ctrl_i.unlink) begin
      if (prev_rd_q == SENT) head_d = next_rd_q;
      if (next_rd_q == SENT) tail_d = prev_rd_q;
      in_list_d[id_idx] = 1'b0;
      count_d           = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= SENT;
      tail_q    <= SENT;
      count_q   <= '0;
      in_list_q <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      in_list_q <= in_list_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cur_q <= cur_d;
    if (ctrl_i.set_err) begin
      err_q <= ctrl_i.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_count_q <= COUNT_W'(count_q);
      out_head_q  <= HEAD_W'(head_q);
      out_value_q <= (head_q == SENT) ? VALUE_W'({VALUE_BITS{1'b1}}) : VALUE_W'(value_rd_q);
      out_err_q   <= err_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.item_count = out_count_q;
  assign rsp_o.head_item  = out_head_q;
  assign rsp_o.head_value = out_value_q;
  assign rsp_o.error_code = out_err_q;

  a_count_matches_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CW'($countones(in_list_q)))
    else $error("item count differs from listed slots");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == SENT) == (count_q == '0))
    else $error("head and item count disagree on empty list");

  a_empty_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q == SENT) == (head_q == SENT))
    else $error("head and tail disagree on empty list");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |=> out_valid_q)
    else $error("loaded response not presented");

endmodule

// ===== design/sorted_tick_list_engine_unit.sv =====
// Sorted tick list engine: one doubly linked list of MAX_ITEMS slots around a sentinel.
// Each command word (clear, sorted insert, insert at tail, remove) returns one response
// word with item count, head slot, head value and error code. Clear and rejected commands
// go straight to the head read; remove passes through the unlink state, a tail insert
// through the LINK1 and LINK2 states, and a sorted insert first walks past each listed node
// whose value is not larger, stopping in front of a larger value or at the sentinel. The walk
// reads one node per cycle through the single read port of the link and value memories.
// The response sits in an output register, so the next command is accepted while an
// earlier response still waits; a second response holds the block until the first is
// taken. No clearing pass is needed after reset.
module sorted_tick_list_engine_unit import stl_pkg::*; #(
  parameter int MAX_ITEMS  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stl_cmd_if.sink   cmd_i,
  stl_rsp_if.source rsp_o
);

  stl_ctrl_t ctrl;
  stl_stat_t stat;

  stl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  stl_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .rsp_o  (rsp_o),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule

// ===== tb/sorted_tick_list_engine_unit_tb.sv =====
// Self-checking testbench for the sorted tick list engine: random and directed list commands.
module sorted_tick_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stl_pkg::*;

  localparam int SLOTS         = 16;
  localparam int SENT          = SLOTS;
  localparam int CLK_PERIOD    = 12;
  localparam int RANDOM_WORDS  = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int MAX_PRINTS    = 40;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [HEAD_W-1:0]  head;
    logic [VALUE_W-1:0] value;
    logic [ERR_W-1:0]   err;
  } status_t;

  // Shadow copy of the list; predicts one status word per accepted command.
  class tick_list_tracker;
    logic [HEAD_W-1:0]  next_of[SENT+1];
    logic [HEAD_W-1:0]  prev_of[SENT+1];
    logic [VALUE_W-1:0] key_of[SLOTS];
    bit                 on_list[SLOTS];
    int unsigned        count;
    status_t            expected_status[$];
    int                 errors;

    function new();
      foreach (key_of[i]) key_of[i] = '0;
      errors = 0;
      empty_list();
    endfunction

    function void empty_list();
      foreach (next_of[i]) begin
        next_of[i] = '0;
        prev_of[i] = '0;
      end
      foreach (on_list[i]) on_list[i] = 1'b0;
      next_of[SENT] = HEAD_W'(SENT);
      prev_of[SENT] = HEAD_W'(SENT);
      count = 0;
    endfunction

    function void note_command(cmd_e c, logic [ID_W-1:0] id, logic [VALUE_W-1:0] v);
      status_t st;
      int      pos;
      int      nxt;
      int      prv;
      int      steps;
      bit      walking;
      err_e    e;
      e = ERR_OK;
      case (c)
        CMD_CLEAR: empty_list();
        CMD_REMOVE: begin
          if (!on_list[id]) begin
            e = ERR_ABSENT;
          end else begin
            nxt = next_of[id];
            prv = prev_of[id];
            prev_of[nxt] = HEAD_W'(prv);
            next_of[prv] = HEAD_W'(nxt);
            on_list[id] = 1'b0;
            if (count > 0) count--;
          end
        end
        default: begin
          if (on_list[id]) begin
            e = ERR_LISTED;
          end else begin
            key_of[id] = v;
            if (c == CMD_INSERT_END || v == {VALUE_W{1'b1}}) begin
              pos = prev_of[SENT];
            end else begin
              // skip every key <= v so equal keys keep arrival order
              pos = SENT;
              steps = 0;
              walking = 1'b1;
              while (walking && steps < SLOTS) begin
                nxt = next_of[pos];
                if (nxt == SENT || key_of[nxt] > v) begin
                  walking = 1'b0;
                end else begin
                  pos = nxt;
                  steps++;
                end
              end
            end
            nxt = next_of[pos];
            next_of[id] = HEAD_W'(nxt);
            prev_of[id] = HEAD_W'(pos);
            prev_of[nxt] = HEAD_W'(id);
            next_of[pos] = HEAD_W'(id);
            on_list[id] = 1'b1;
            count++;
          end
        end
      endcase
      st.count = COUNT_W'(count);
      st.head  = next_of[SENT];
      st.value = (next_of[SENT] == SENT) ? {VALUE_W{1'b1}} : key_of[next_of[SENT]];
      st.err   = e;
      expected_status.push_back(st);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_status(status_t got);
      status_t exp;
      if (expected_status.size() == 0) begin
        report($sformatf("status word with no command pending (head %0d)", got.head));
        return;
      end
      exp = expected_status.pop_front();
      if (got.count !== exp.count)
        report($sformatf("item_count expected %0d got %0d", exp.count, got.count));
      if (got.head !== exp.head)
        report($sformatf("head_item expected %0d got %0d", exp.head, got.head));
      if (got.value !== exp.value)
        report($sformatf("head_value expected 0x%0h got 0x%0h", exp.value, got.value));
      if (got.err !== exp.err)
        report($sformatf("error_code expected %0d got %0d", exp.err, got.err));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  stl_cmd_if cmd_if ();
  stl_rsp_if rsp_if ();

  sorted_tick_list_engine_unit #(
    .MAX_ITEMS (SLOTS),
    .VALUE_BITS(VALUE_W)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  tick_list_tracker sb = new();

  bit steady   = 1'b0;  // no idling on either side
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [ID_W-1:0] pick_slot(bit want_listed);
    logic [ID_W-1:0] id;
    int              tries;
    id = ID_W'($urandom);
    tries = 0;
    while (sb.on_list[id] != want_listed && tries < 32) begin
      id = ID_W'($urandom);
      tries++;
    end
    return id;
  endfunction

  task automatic send_word(cmd_e c, logic [ID_W-1:0] id, logic [VALUE_W-1:0] v);
    if (!steady && $urandom_range(0, 99) < 37) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= c;
    cmd_if.item_id    <= id;
    cmd_if.item_value <= v;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(c, id, v);
  endtask

  // Response side
  initial begin
    status_t got;
    bit      hold_taken;
    int      hold_left;
    hold_taken = 1'b0;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.count = rsp_if.item_count;
        got.head  = rsp_if.head_item;
        got.value = rsp_if.head_value;
        got.err   = rsp_if.error_code;
        sb.check_status(got);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (steady) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // Command side
  initial begin
    cmd_e               c;
    logic [ID_W-1:0]    id;
    logic [VALUE_W-1:0] v;
    int                 target;
    int                 roll;
    int                 waited;
    rst_ni            <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= CMD_CLEAR;
    cmd_if.item_id    <= '0;
    cmd_if.item_value <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_REMOVE, 4'd3, 32'hDEAD_BEEF);        // remove from an empty list
    send_word(CMD_INSERT_SORTED, 4'd0, 32'h0000_0100);
    send_word(CMD_INSERT_SORTED, 4'd1, 32'h0000_0000); // new head
    send_word(CMD_INSERT_SORTED, 4'd2, 32'h0000_0100); // equal key lands after slot 0
    send_word(CMD_INSERT_SORTED, 4'd15, 32'hFFFF_FFFF); // max key goes to the tail
    send_word(CMD_INSERT_SORTED, 4'd5, 32'hFFFF_FFFE);
    send_word(CMD_INSERT_END, 4'd7, 32'h0000_0000);    // tail despite smallest key
    send_word(CMD_INSERT_SORTED, 4'd0, 32'h0000_0005); // already listed
    send_word(CMD_INSERT_END, 4'd15, 32'h0000_0005);   // already listed
    send_word(CMD_INSERT_SORTED, 4'd9, 32'h0000_0100);
    send_word(CMD_INSERT_SORTED, 4'd10, 32'h8000_0000);
    send_word(CMD_INSERT_SORTED, 4'd3, 32'h5555_5555);
    send_word(CMD_INSERT_END, 4'd4, 32'hAAAA_AAAA);
    send_word(CMD_REMOVE, 4'd1, 32'h0);                // head
    send_word(CMD_REMOVE, 4'd4, 32'h0);                // tail
    send_word(CMD_REMOVE, 4'd2, 32'h0);                // middle
    send_word(CMD_REMOVE, 4'd2, 32'h0);                // no longer listed
    send_word(CMD_CLEAR, 4'd9, 32'hFFFF_FFFF);
    send_word(CMD_REMOVE, 4'd0, 32'h0);
    send_word(CMD_INSERT_END, 4'd0, 32'hFFFF_FFFF);
    send_word(CMD_INSERT_SORTED, 4'd1, 32'hFFFF_FFFF);
    send_word(CMD_INSERT_SORTED, 4'd2, 32'h0000_0000);
    send_word(CMD_CLEAR, 4'd0, 32'h0);

    target = 0;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      // fill level drifts so the list spends time empty, half full and full
      if (k % 64 == 0) target = $urandom_range(0, SLOTS);
      if (k == 300) hold_req = 1'b1;
      steady = (k >= 600 && k < 900);
      if (k == 1200) begin
        cmd_if.valid <= 1'b0;
        do @(posedge clk_i); while (sb.expected_status.size() != 0);
      end
      roll = $urandom_range(0, 99);
      id = ID_W'($urandom);
      if (roll < 2) begin
        c = CMD_CLEAR;
      end else if (roll < 12) begin
        c = cmd_e'($urandom_range(1, 3));
      end else if (sb.count < target) begin
        c = ($urandom_range(0, 99) < 70) ? CMD_INSERT_SORTED : CMD_INSERT_END;
        id = pick_slot(1'b0);
      end else begin
        c = CMD_REMOVE;
        id = pick_slot(1'b1);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = $urandom;
        4, 5, 6:    v = VALUE_W'($urandom_range(0, 15));  // many equal keys
        7:          v = {VALUE_W{1'b1}};
        8:          v = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(1, 8));
        default:    v = '0;
      endcase
      send_word(c, id, v);
    end
    steady = 1'b0;

    cmd_if.valid <= 1'b0;
    waited = 0;
    while (sb.expected_status.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.expected_status.size() != 0)
      sb.report($sformatf("%0d status words never arrived", sb.expected_status.size()));

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
